### src/dtq_pkg.sv
// shared types and constants of the deadline timer queue
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;

  // action codes
  localparam logic [2:0] ACT_TICK         = 3'd0;
  localparam logic [2:0] ACT_ADD          = 3'd1;
  localparam logic [2:0] ACT_CANCEL_OWNER = 3'd2;
  localparam logic [2:0] ACT_CANCEL_SIG   = 3'd3;
  localparam logic [2:0] ACT_RESCHED_OWN  = 3'd4;
  localparam logic [2:0] ACT_RESCHED_SIG  = 3'd5;

  // result codes
  localparam logic       KIND_EXPIRY      = 1'b0;
  localparam logic       KIND_DONE        = 1'b1;
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam int TIME_BITS = 48;
  localparam int SIG_BITS  = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_RD,
    ST_F_EV,
    ST_EMIT,
    ST_F_END,
    ST_I_START,
    ST_I_RD,
    ST_I_EV,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_op;
    logic filter_start;
    logic filter_read;
    logic filter_step;
    logic load_exp;
    logic filter_end;
    logic ins_start;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic set_full;
    logic set_nf;
    logic show_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] act;
    logic       filter_at_end;
    logic       hit;
    logic       full;
    logic       ins_at_zero;
    logic       later;
    logic       found;
  } sts_t;

endpackage
`default_nettype wire

### src/dtq_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/dtq_ctrl.sv
// sequencing state machine of the deadline timer queue
`timescale 1ns / 1ps
`default_nettype none
module dtq_ctrl import dtq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] action,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          case (action)
            ACT_TICK, ACT_CANCEL_OWNER, ACT_CANCEL_SIG,
            ACT_RESCHED_OWN, ACT_RESCHED_SIG: begin
              cmd.filter_start = 1'b1;
              state_next = ST_F_RD;
            end
            ACT_ADD: state_next = ST_I_START;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_F_RD: begin
        if (sts.filter_at_end) begin
          state_next = ST_F_END;
        end else begin
          cmd.filter_read = 1'b1;
          state_next = ST_F_EV;
        end
      end
      ST_F_EV: begin
        cmd.filter_step = 1'b1;
        if (sts.hit && sts.act == ACT_TICK) begin
          cmd.load_exp = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_F_RD;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_F_RD;
        end
      end
      ST_F_END: begin
        cmd.filter_end = 1'b1;
        case (sts.act)
          ACT_RESCHED_OWN: begin
            if (sts.found) begin
              state_next = ST_I_START;
            end else begin
              cmd.set_nf = 1'b1;
              state_next = ST_DONE;
            end
          end
          ACT_RESCHED_SIG: state_next = ST_I_START;
          default: state_next = ST_DONE;
        endcase
      end
      ST_I_START: begin
        if (sts.full) begin
          cmd.set_full = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.ins_start = 1'b1;
          state_next = ST_I_RD;
        end
      end
      ST_I_RD: begin
        if (sts.ins_at_zero) begin
          cmd.ins_place = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.ins_read = 1'b1;
          state_next = ST_I_EV;
        end
      end
      ST_I_EV: begin
        if (sts.later) begin
          cmd.ins_shift = 1'b1;
          state_next = ST_I_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        cmd.show_done = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // no new transfer is taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  // an offered result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result withdrawn");
  // input is only taken when idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");

endmodule
`default_nettype wire

### src/dtq_dp.sv
// record storage, counters and result registers of the timer queue
`timescale 1ns / 1ps
`default_nettype none
module dtq_dp import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int OWNER_BITS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [2:0]           action,
  input  wire logic [TIME_BITS-1:0] now_time,
  input  wire logic [TIME_BITS-1:0] delay,
  input  wire logic [7:0]           owner_id,
  input  wire logic [SIG_BITS-1:0]  signal_code,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic                      kind,
  output logic [1:0]                status,
  output logic [7:0]                owner_id_res,
  output logic [SIG_BITS-1:0]       signal_code_res,
  output logic [TIME_BITS-1:0]      due_time,
  output logic                      last
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + OWNER_BITS + SIG_BITS;

  // control state
  logic [CW-1:0] count, rd, wr, idx;
  logic          popping, found;
  logic [1:0]    status_reg;

  // payload registers
  logic [TIME_BITS-1:0]  cur_time, new_due;
  logic [2:0]            op_act;
  logic [TIME_BITS-1:0]  op_delay;
  logic [OWNER_BITS-1:0] op_owner;
  logic [SIG_BITS-1:0]   op_sig, saved_sig, new_sig;
  logic [OWNER_BITS-1:0] exp_owner;
  logic [SIG_BITS-1:0]   exp_sig;
  logic [TIME_BITS-1:0]  exp_due;

  // ram access
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]  r_due;
  logic [OWNER_BITS-1:0] r_owner;
  logic [SIG_BITS-1:0]   r_sig;
  logic [CW-1:0]         idx_m1;
  logic [TIME_BITS:0]    due_sum;
  logic                  own_eq, sig_eq, hit;

  assign {r_due, r_owner, r_sig} = ram_rdata;
  assign idx_m1  = idx - CW'(1);
  assign due_sum = {1'b0, cur_time} + {1'b0, op_delay};
  assign own_eq  = r_owner == op_owner;
  assign sig_eq  = r_sig == op_sig;

  // match rule of the running pass
  always_comb begin
    case (op_act)
      ACT_TICK:         hit = popping && (r_due <= cur_time);
      ACT_CANCEL_OWNER: hit = own_eq;
      ACT_CANCEL_SIG,
      ACT_RESCHED_SIG:  hit = own_eq && sig_eq;
      ACT_RESCHED_OWN:  hit = own_eq && !found;
      default:          hit = 1'b0;
    endcase
  end

  // ram port selection
  always_comb begin
    ram_re    = cmd.filter_read || cmd.ins_read;
    ram_raddr = cmd.filter_read ? rd[IW-1:0] : idx_m1[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.filter_step && !hit) begin
      ram_we    = 1'b1;
      ram_waddr = wr[IW-1:0];
    end else if (cmd.ins_shift) begin
      ram_we    = 1'b1;
    end else if (cmd.ins_place) begin
      ram_we    = 1'b1;
      ram_wdata = {new_due, op_owner, new_sig};
    end
  end

  dtq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd         <= '0;
      wr         <= '0;
      idx        <= '0;
      popping    <= 1'b0;
      found      <= 1'b0;
      status_reg <= STATUS_OK;
      cur_time   <= '0;
    end else begin
      if (cmd.load_op) begin
        status_reg <= STATUS_OK;
        if (action == ACT_TICK) begin
          cur_time <= now_time;
        end
      end
      if (cmd.filter_start) begin
        rd      <= '0;
        wr      <= '0;
        popping <= 1'b1;
        found   <= 1'b0;
      end
      if (cmd.filter_step) begin
        rd <= rd + CW'(1);
        if (hit) begin
          found <= 1'b1;
        end else begin
          wr      <= wr + CW'(1);
          popping <= 1'b0;
        end
      end
      if (cmd.filter_end) begin
        count <= wr;
      end
      if (cmd.ins_start) begin
        idx <= count;
      end
      if (cmd.ins_shift) begin
        idx <= idx_m1;
      end
      if (cmd.ins_place) begin
        count <= count + CW'(1);
      end
      if (cmd.set_full) begin
        status_reg <= STATUS_FULL;
      end
      if (cmd.set_nf) begin
        status_reg <= STATUS_NOT_FOUND;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_act   <= action;
      op_delay <= delay;
      op_owner <= OWNER_BITS'(owner_id);
      op_sig   <= signal_code;
    end
    if (cmd.filter_step && hit) begin
      saved_sig <= r_sig;
    end
    if (cmd.ins_start) begin
      new_due <= due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];
      new_sig <= (op_act == ACT_RESCHED_OWN) ? saved_sig : op_sig;
    end
    if (cmd.load_exp) begin
      exp_owner <= r_owner;
      exp_sig   <= r_sig;
      exp_due   <= r_due;
    end
  end

  // status to controller
  always_comb begin
    sts.act           = op_act;
    sts.filter_at_end = rd == count;
    sts.hit           = hit;
    sts.full          = count == CW'(QUEUE_DEPTH);
    sts.ins_at_zero   = idx == '0;
    sts.later         = r_due > new_due;
    sts.found         = found;
  end

  // result fields
  assign kind            = cmd.show_done ? KIND_DONE : KIND_EXPIRY;
  assign status          = cmd.show_done ? status_reg : STATUS_OK;
  assign owner_id_res    = cmd.show_done ? 8'd0 : 8'(exp_owner);
  assign signal_code_res = cmd.show_done ? '0 : exp_sig;
  assign due_time        = cmd.show_done ? '0 : exp_due;
  assign last            = cmd.show_done;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("record count beyond depth");
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    wr <= rd) else $error("compaction write ahead of read");
  a_place_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |-> (idx <= count) && (count < CW'(QUEUE_DEPTH)))
    else $error("insert slot out of range");

endmodule
`default_nettype wire

### src/deadline_timer_queue_top.sv
// top level of the deadline timer queue
// a command reads and judges each stored record that it walks; a tick also offers
// one expiry notice per expired record, add walks back to the insert slot,
// and reschedule does both.
// one item at a time; the single ram read port of the record store sets the pace.
// reset empties the queue and clears the current time; stored records need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module deadline_timer_queue_top import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int OWNER_BITS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           action,
  input  wire logic [TIME_BITS-1:0] now_time,
  input  wire logic [TIME_BITS-1:0] delay,
  input  wire logic [7:0]           owner_id,
  input  wire logic [SIG_BITS-1:0]  signal_code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      kind,
  output logic [1:0]                status,
  output logic [7:0]                owner_id_res,
  output logic [SIG_BITS-1:0]       signal_code_res,
  output logic [TIME_BITS-1:0]      due_time,
  output logic                      last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // record store and result registers
  dtq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .OWNER_BITS(OWNER_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .action          (action),
    .now_time        (now_time),
    .delay           (delay),
    .owner_id        (owner_id),
    .signal_code     (signal_code),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .status          (status),
    .owner_id_res    (owner_id_res),
    .signal_code_res (signal_code_res),
    .due_time        (due_time),
    .last            (last)
  );

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the deadline timer queue: directed table plus random traffic against a predictor
`timescale 1ns / 1ps
module tb;
  import dtq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [47:0] MAX_TIME = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  owner;
    logic [15:0] sig;
    logic [47:0] due;
    logic        last;
  } notice_t;

  typedef struct {
    logic [2:0]  act;
    logic [47:0] now;
    logic [47:0] dly;
    logic [7:0]  owner;
    logic [15:0] sig;
    logic        has_exp;
    logic [1:0]  exp_status;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = '0;
  logic [47:0] now_time = '0;
  logic [47:0] delay = '0;
  logic [7:0] owner_id = '0;
  logic [15:0] signal_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [1:0] status;
  logic [7:0] owner_id_res;
  logic [15:0] signal_code_res;
  logic [47:0] due_time;
  logic last;

  // predictor state
  logic [47:0] clock_now;
  logic [47:0] rec_due[DEPTH];
  logic [7:0] rec_owner[DEPTH];
  logic [15:0] rec_sig[DEPTH];
  int rec_count;

  notice_t pending_notices[$];
  int errors = 0;
  int rx_hold = 0;
  bit no_idle = 1'b0;

  deadline_timer_queue_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .now_time(now_time), .delay(delay),
    .owner_id(owner_id), .signal_code(signal_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .owner_id_res(owner_id_res),
    .signal_code_res(signal_code_res), .due_time(due_time), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < rec_count; i++) begin
      rec_due[i] = rec_due[i+1];
      rec_owner[i] = rec_owner[i+1];
      rec_sig[i] = rec_sig[i+1];
    end
    rec_count--;
  endfunction

  function automatic logic [1:0] schedule(logic [7:0] own, logic [15:0] sg, logic [47:0] dly);
    logic [48:0] sum;
    logic [47:0] at;
    int pos;
    sum = {1'b0, clock_now} + {1'b0, dly};
    at = sum[48] ? MAX_TIME : sum[47:0];
    if (rec_count >= DEPTH) return STATUS_FULL;
    pos = 0;
    while (pos < rec_count && rec_due[pos] <= at) pos++;
    for (int i = rec_count; i > pos; i--) begin
      rec_due[i] = rec_due[i-1];
      rec_owner[i] = rec_owner[i-1];
      rec_sig[i] = rec_sig[i-1];
    end
    rec_due[pos] = at;
    rec_owner[pos] = own;
    rec_sig[pos] = sg;
    rec_count++;
    return STATUS_OK;
  endfunction

  function automatic void purge(logic [7:0] own, bit by_sig, logic [15:0] sg);
    int wr;
    wr = 0;
    for (int rd = 0; rd < rec_count; rd++) begin
      if (!(rec_owner[rd] == own && (!by_sig || rec_sig[rd] == sg))) begin
        rec_due[wr] = rec_due[rd];
        rec_owner[wr] = rec_owner[rd];
        rec_sig[wr] = rec_sig[rd];
        wr++;
      end
    end
    rec_count = wr;
  endfunction

  // computes the notices one command causes and queues them
  function automatic logic [1:0] predict_notices(cmd_row_t c);
    logic [1:0] st;
    int i;
    notice_t n;
    st = STATUS_OK;
    case (c.act)
      ACT_TICK: begin
        clock_now = c.now;
        while (rec_count > 0 && rec_due[0] <= clock_now) begin
          n = '{KIND_EXPIRY, STATUS_OK, rec_owner[0], rec_sig[0], rec_due[0], 1'b0};
          pending_notices.push_back(n);
          drop_at(0);
        end
      end
      ACT_ADD: st = schedule(c.owner, c.sig, c.dly);
      ACT_CANCEL_OWNER: purge(c.owner, 1'b0, '0);
      ACT_CANCEL_SIG: purge(c.owner, 1'b1, c.sig);
      ACT_RESCHED_OWN: begin
        for (i = 0; i < rec_count; i++) if (rec_owner[i] == c.owner) break;
        if (i >= rec_count) begin
          st = STATUS_NOT_FOUND;
        end else begin
          logic [15:0] keep;
          keep = rec_sig[i];
          drop_at(i);
          st = schedule(c.owner, keep, c.dly);
        end
      end
      ACT_RESCHED_SIG: begin
        purge(c.owner, 1'b1, c.sig);
        st = schedule(c.owner, c.sig, c.dly);
      end
      default: ;
    endcase
    n = '{KIND_DONE, st, 8'd0, 16'd0, 48'd0, 1'b1};
    pending_notices.push_back(n);
    return st;
  endfunction

  // result side: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  // result check on each transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      notice_t got, want;
      got = '{kind, status, owner_id_res, signal_code_res, due_time, last};
      if (pending_notices.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_notices[0];
        pending_notices.delete(0);
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0h actual %0h", $time, want.kind, got.kind);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0h actual %0h", $time, want.status, got.status);
          errors++;
        end
        if (got.owner !== want.owner) begin
          $display("%0t: owner expected %0h actual %0h", $time, want.owner, got.owner);
          errors++;
        end
        if (got.sig !== want.sig) begin
          $display("%0t: signal expected %0h actual %0h", $time, want.sig, got.sig);
          errors++;
        end
        if (got.due !== want.due) begin
          $display("%0t: due expected %0h actual %0h", $time, want.due, got.due);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0h actual %0h", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // one command transfer, with an optional random gap before it
  task automatic send_cmd(cmd_row_t c);
    logic [1:0] st;
    while (!no_idle && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= c.act;
    now_time <= c.now;
    delay <= c.dly;
    owner_id <= c.owner;
    signal_code <= c.sig;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = predict_notices(c);
    if (c.has_exp && st !== c.exp_status) begin
      $display("%0t: table status expected %0h predicted %0h", $time, c.exp_status, st);
      errors++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_notices.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  function automatic cmd_row_t mk(logic [2:0] a, logic [47:0] nw, logic [47:0] d,
                                  logic [7:0] o, logic [15:0] s, logic he, logic [1:0] es);
    cmd_row_t c;
    c.act = a; c.now = nw; c.dly = d; c.owner = o; c.sig = s;
    c.has_exp = he; c.exp_status = es;
    return c;
  endfunction

  // random command, mostly ops on a small owner pool so matches occur
  function automatic cmd_row_t rand_cmd();
    cmd_row_t c;
    int r;
    r = $urandom_range(99);
    c.act = r < 25 ? ACT_TICK : r < 60 ? ACT_ADD : r < 70 ? ACT_CANCEL_OWNER :
            r < 78 ? ACT_CANCEL_SIG : r < 87 ? ACT_RESCHED_OWN : r < 96 ? ACT_RESCHED_SIG :
            3'($urandom_range(7));
    c.now = $urandom_range(9) == 0 ? 48'({$urandom, $urandom}) :
            48'(clock_now + 48'($urandom_range(300)));
    c.dly = $urandom_range(19) == 0 ? 48'({$urandom, $urandom}) : 48'($urandom_range(400));
    c.owner = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    c.sig = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2));
    c.has_exp = 1'b0;
    c.exp_status = STATUS_OK;
    return c;
  endfunction

  initial begin
    cmd_row_t dir_rows[$];
    clock_now = '0;
    rec_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty queue, errors, extremes, fill to full, equal deadlines
    dir_rows.push_back(mk(ACT_TICK, 48'd0, 48'd0, 8'd0, 16'd0, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_RESCHED_OWN, 48'd0, 48'd5, 8'd7, 16'd0, 1'b1,
                          STATUS_NOT_FOUND));
    dir_rows.push_back(mk(3'd6, 48'd0, 48'd0, 8'd1, 16'd1, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(3'd7, MAX_TIME, MAX_TIME, 8'hFF, 16'hFFFF, 1'b1, STATUS_OK));
    for (int i = 0; i < 16; i++)
      dir_rows.push_back(mk(ACT_ADD, 48'd0, 48'(i % 3), 8'(i % 2 ? 8'hFF : 8'h00),
                            16'(i), 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_ADD, 48'd0, MAX_TIME, 8'hAA, 16'hFFFF, 1'b1, STATUS_FULL));
    dir_rows.push_back(mk(ACT_RESCHED_SIG, 48'd0, 48'd9, 8'h55, 16'h1, 1'b1, STATUS_FULL));
    dir_rows.push_back(mk(ACT_RESCHED_OWN, 48'd0, MAX_TIME, 8'hFF, 16'd0, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_CANCEL_SIG, 48'd0, 48'd0, 8'h00, 16'd4, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_TICK, 48'd1, 48'd0, 8'd0, 16'd0, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_CANCEL_OWNER, 48'd0, 48'd0, 8'h00, 16'd0, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_TICK, 48'hFFFF_FFFF_FFF0, 48'd0, 8'd0, 16'd0, 1'b1,
                          STATUS_OK));
    dir_rows.push_back(mk(ACT_ADD, 48'd0, MAX_TIME, 8'h12, 16'h8000, 1'b1, STATUS_OK));
    dir_rows.push_back(mk(ACT_TICK, MAX_TIME, 48'd0, 8'd0, 16'd0, 1'b1, STATUS_OK));
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    wait_drained();
    // back to small times after the extremes
    send_cmd(mk(ACT_TICK, 48'd0, 48'd0, 8'd0, 16'd0, 1'b1, STATUS_OK));

    // random part, with a stretch free of gaps and stalls and a long receiver hold-off
    for (int n = 0; n < 160; n++) begin
      if (n == 40) no_idle = 1'b1;
      if (n == 70) no_idle = 1'b0;
      if (n == 90) rx_hold = 400;
      if (n == 130) wait_drained();
      send_cmd(rand_cmd());
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_notices.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
